@@ rtl/exlex_pkg.sv @@
// ----------------------------------------------------------------------------
// exlex_pkg: shared types and constants for the expression lexer
// Token kinds, scanner modes, character classes and the result word layout.
// ----------------------------------------------------------------------------
package exlex_pkg;

  typedef enum logic [4:0] {
    K_ILLEGAL  = 5'd0,
    K_END      = 5'd1,
    K_IDENT    = 5'd2,
    K_NUMBER   = 5'd3,
    K_STRING   = 5'd4,
    K_ASSIGN   = 5'd5,
    K_EQ       = 5'd6,
    K_PLUS     = 5'd7,
    K_MINUS    = 5'd8,
    K_BANG     = 5'd9,
    K_NOTEQ    = 5'd10,
    K_SLASH    = 5'd11,
    K_STAR     = 5'd12,
    K_LT       = 5'd13,
    K_LEQ      = 5'd14,
    K_GT       = 5'd15,
    K_GEQ      = 5'd16,
    K_SEMI     = 5'd17,
    K_LPAREN   = 5'd18,
    K_RPAREN   = 5'd19,
    K_COMMA    = 5'd20,
    K_LBRACE   = 5'd21,
    K_RBRACE   = 5'd22,
    K_LBRACKET = 5'd23,
    K_RBRACKET = 5'd24
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_IDENT   = 4'd1,
    M_INT     = 4'd2,
    M_FRAC    = 4'd3,
    M_EXP0    = 4'd4,
    M_EXPD    = 4'd5,
    M_STR     = 4'd6,
    M_COMMENT = 4'd7,
    M_PEQ     = 4'd8,
    M_PBANG   = 4'd9,
    M_PLT     = 4'd10,
    M_PGT     = 4'd11
  } mode_t;

  // one result word, kept in the output queue
  typedef struct packed {
    logic        last;
    logic [15:0] line;
    logic [15:0] len;
    logic [15:0] start;
    kind_t       kind;
  } tok_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LO_D   = 8'h64;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_suffix(input logic [7:0] c);
    return (c == CH_LO_D) || (c == CH_UP_D) || (c == CH_LO_F) || (c == CH_UP_F);
  endfunction

endpackage

@@ rtl/expression_lexer_core.sv @@
// ----------------------------------------------------------------------------
// expression_lexer_core: streaming expression tokenizer
// Scans one source byte per word and emits tokens with offset, length, line.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries source bytes, one per word; a byte of 0 ends the
//   input, produces an END token and restarts offset and line counters.
//   m_* channel carries tokens; tlast marks the final token caused by one
//   input byte (a byte can close a pending token and form one of its own).
// Throughput: one byte per cycle. The scanner state updates in the cycle a
//   byte is accepted, and its tokens (zero, one or two) are written into a
//   four-word output queue that drains one token per cycle while m_tready
//   is high. A two-token byte always leaves the scanner idle, so another one
//   needs a token-free byte first; the queue never holds more than two words
//   with an always-ready receiver and the input never stalls then.
// Output: a byte's tokens are registered into the queue, and a second token
//   from the same byte follows the first one out of it.
// Stalls: s_tready drops while fewer than two queue slots are free, so a
//   stalled receiver holds the scanner without losing tokens.
// Reset: rst (synchronous, active high) empties the queue, sets the scanner
//   to idle, offset and token start to 0 and the line count to 1.
// ----------------------------------------------------------------------------
module expression_lexer_core #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  // token stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [4:0] kind, [20:5] start_offset,
                                 // [36:21] text_length, [52:37] line_no,
                                 // [55:53] zero
  output logic        m_tlast    // last
);

  localparam int OB = OFFSET_BITS;
  // wide enough for an end offset one past the saturated maximum, and at least 17 bits
  localparam int WB = (OB + 1 > 17) ? OB + 1 : 17;
  localparam logic [OB-1:0] OFF_MAX = '1;

  // scanner state
  exlex_pkg::mode_t mode, mode_next;
  logic [OB-1:0]    char_offset, char_offset_next;
  logic [OB-1:0]    token_start, token_start_next;
  logic [15:0]      line_count, line_count_next;

  // output queue
  exlex_pkg::tok_t  queue [4];
  logic [1:0]       wr_ptr, rd_ptr;
  logic [2:0]       count;

  logic             in_fire, out_fire;

  // clamp an offset-sized value to the 16-bit result fields
  function automatic logic [15:0] clamp16(input logic [OB:0] v);
    logic [WB-1:0] w;
    w = WB'(v);
    return (w > WB'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  // scan logic
  logic [7:0]       c;
  logic             again;
  logic             saw_end;
  logic             e0_valid, e1_valid;
  exlex_pkg::tok_t  e0, e1;
  logic [OB:0]      off_x, off_x1, ts_x;
  logic [OB:0]      span_end;
  logic             span_sel;   // span_end = off + 1 (number suffix)
  logic [1:0]       pend_idx;

  assign c      = s_tdata;
  assign off_x  = {1'b0, char_offset};
  assign off_x1 = off_x + (OB+1)'(1);
  assign ts_x   = {1'b0, token_start};
  assign span_end = span_sel ? off_x1 : off_x;
  assign pend_idx = 2'(mode - exlex_pkg::M_PEQ);

  always_comb begin
    mode_next        = mode;
    token_start_next = token_start;
    line_count_next  = line_count;
    again            = 1'b0;
    saw_end          = 1'b0;
    span_sel         = 1'b0;
    e0_valid         = 1'b0;
    e1_valid         = 1'b0;
    e0               = '0;
    e1               = '0;
    e0.line          = line_count;
    e1.line          = line_count;
    // spans run from token_start to the end offset, never negative
    e0.start         = clamp16(ts_x);
    e0.len           = clamp16((span_end >= ts_x) ? (span_end - ts_x) : '0);

    // first half: the mode the byte arrives in
    unique case (mode)
      exlex_pkg::M_IDENT: begin
        if (!(exlex_pkg::is_alpha(c) || exlex_pkg::is_digit(c) ||
              c == exlex_pkg::CH_USCORE || c == exlex_pkg::CH_SQUOTE)) begin
          e0_valid = 1'b1;
          e0.kind  = exlex_pkg::K_IDENT;
          again    = 1'b1;
        end
      end
      exlex_pkg::M_INT, exlex_pkg::M_FRAC, exlex_pkg::M_EXP0,
      exlex_pkg::M_EXPD: begin
        if (mode == exlex_pkg::M_EXP0 &&
            (exlex_pkg::is_digit(c) || c == exlex_pkg::CH_PLUS ||
             c == exlex_pkg::CH_MINUS)) begin
          mode_next = exlex_pkg::M_EXPD;
        end else if (mode != exlex_pkg::M_EXP0 && exlex_pkg::is_digit(c)) begin
          mode_next = mode;
        end else if (mode == exlex_pkg::M_INT && c == exlex_pkg::CH_DOT) begin
          mode_next = exlex_pkg::M_FRAC;
        end else if ((mode == exlex_pkg::M_INT || mode == exlex_pkg::M_FRAC) &&
                     (c == exlex_pkg::CH_LO_E || c == exlex_pkg::CH_UP_E)) begin
          mode_next = exlex_pkg::M_EXP0;
        end else if (exlex_pkg::is_suffix(c)) begin
          // suffix belongs to the number
          e0_valid  = 1'b1;
          e0.kind   = exlex_pkg::K_NUMBER;
          span_sel  = 1'b1;
          mode_next = exlex_pkg::M_IDLE;
        end else begin
          e0_valid = 1'b1;
          e0.kind  = exlex_pkg::K_NUMBER;
          again    = 1'b1;
        end
      end
      exlex_pkg::M_STR: begin
        if (c == exlex_pkg::CH_DQUOTE) begin
          e0_valid  = 1'b1;
          e0.kind   = exlex_pkg::K_STRING;
          mode_next = exlex_pkg::M_IDLE;
        end else if (c == exlex_pkg::CH_NUL) begin
          // unterminated string: flush the text, then END
          e0_valid = 1'b1;
          e0.kind  = exlex_pkg::K_STRING;
          again    = 1'b1;
        end
      end
      exlex_pkg::M_COMMENT: begin
        if (c == exlex_pkg::CH_NL) begin
          if (line_count < exlex_pkg::LINE_MAX) line_count_next = line_count + 16'd1;
          mode_next = exlex_pkg::M_IDLE;
        end else if (c == exlex_pkg::CH_NUL) begin
          again = 1'b1;
        end
      end
      exlex_pkg::M_PEQ, exlex_pkg::M_PBANG, exlex_pkg::M_PLT,
      exlex_pkg::M_PGT: begin
        e0_valid = 1'b1;
        if (c == exlex_pkg::CH_EQ) begin
          e0.len    = 16'd2;
          mode_next = exlex_pkg::M_IDLE;
          unique case (pend_idx)
            2'd0:    e0.kind = exlex_pkg::K_EQ;
            2'd1:    e0.kind = exlex_pkg::K_NOTEQ;
            2'd2:    e0.kind = exlex_pkg::K_LEQ;
            default: e0.kind = exlex_pkg::K_GEQ;
          endcase
        end else begin
          e0.len = 16'd1;
          again  = 1'b1;
          unique case (pend_idx)
            2'd0:    e0.kind = exlex_pkg::K_ASSIGN;
            2'd1:    e0.kind = exlex_pkg::K_BANG;
            2'd2:    e0.kind = exlex_pkg::K_LT;
            default: e0.kind = exlex_pkg::K_GT;
          endcase
        end
      end
      default: again = 1'b1;
    endcase

    // second half: the byte starts something from idle
    e1.start = clamp16(off_x);
    e1.len   = 16'd1;
    if (again) begin
      mode_next        = exlex_pkg::M_IDLE;
      token_start_next = char_offset;
      e1_valid         = 1'b1;
      unique case (c)
        exlex_pkg::CH_NUL: begin
          e1.kind = exlex_pkg::K_END;
          e1.len  = 16'd0;
          saw_end = 1'b1;
        end
        exlex_pkg::CH_HASH: begin
          e1_valid  = 1'b0;
          mode_next = exlex_pkg::M_COMMENT;
        end
        exlex_pkg::CH_DQUOTE: begin
          e1_valid         = 1'b0;
          token_start_next = (char_offset < OFF_MAX) ? char_offset + OB'(1) : OFF_MAX;
          mode_next        = exlex_pkg::M_STR;
        end
        exlex_pkg::CH_EQ:     begin e1_valid = 1'b0; mode_next = exlex_pkg::M_PEQ;   end
        exlex_pkg::CH_BANG:   begin e1_valid = 1'b0; mode_next = exlex_pkg::M_PBANG; end
        exlex_pkg::CH_LT:     begin e1_valid = 1'b0; mode_next = exlex_pkg::M_PLT;   end
        exlex_pkg::CH_GT:     begin e1_valid = 1'b0; mode_next = exlex_pkg::M_PGT;   end
        exlex_pkg::CH_PLUS:   e1.kind = exlex_pkg::K_PLUS;
        exlex_pkg::CH_MINUS:  e1.kind = exlex_pkg::K_MINUS;
        exlex_pkg::CH_SLASH:  e1.kind = exlex_pkg::K_SLASH;
        exlex_pkg::CH_STAR:   e1.kind = exlex_pkg::K_STAR;
        exlex_pkg::CH_SEMI:   e1.kind = exlex_pkg::K_SEMI;
        exlex_pkg::CH_LPAREN: e1.kind = exlex_pkg::K_LPAREN;
        exlex_pkg::CH_RPAREN: e1.kind = exlex_pkg::K_RPAREN;
        exlex_pkg::CH_COMMA:  e1.kind = exlex_pkg::K_COMMA;
        exlex_pkg::CH_LBRACE: e1.kind = exlex_pkg::K_LBRACE;
        exlex_pkg::CH_RBRACE: e1.kind = exlex_pkg::K_RBRACE;
        exlex_pkg::CH_LBRACK: e1.kind = exlex_pkg::K_LBRACKET;
        exlex_pkg::CH_RBRACK: e1.kind = exlex_pkg::K_RBRACKET;
        default: begin
          priority if (exlex_pkg::is_space(c)) begin
            e1_valid = 1'b0;
            if (c == exlex_pkg::CH_NL && line_count < exlex_pkg::LINE_MAX) begin
              line_count_next = line_count + 16'd1;
            end
          end else if (exlex_pkg::is_alpha(c) || c == exlex_pkg::CH_USCORE) begin
            e1_valid  = 1'b0;
            mode_next = exlex_pkg::M_IDENT;
          end else if (exlex_pkg::is_digit(c)) begin
            e1_valid  = 1'b0;
            mode_next = exlex_pkg::M_INT;
          end else begin
            e1.kind = exlex_pkg::K_ILLEGAL;
          end
        end
      endcase
    end

    // the final token of this byte carries tlast
    e0.last = !e1_valid;
    e1.last = 1'b1;

    // END puts every counter back to its reset value
    if (saw_end) begin
      mode_next        = exlex_pkg::M_IDLE;
      char_offset_next = '0;
      token_start_next = '0;
      line_count_next  = 16'd1;
    end else begin
      char_offset_next = (char_offset < OFF_MAX) ? char_offset + OB'(1) : OFF_MAX;
    end
  end

  // handshakes: hold input until two free slots are available
  assign s_tready = (count <= 3'd2);
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = (count != 3'd0);
  assign out_fire = m_tvalid && m_tready;

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= exlex_pkg::M_IDLE;
      char_offset <= '0;
      token_start <= '0;
      line_count  <= 16'd1;
    end else if (in_fire) begin
      mode        <= mode_next;
      char_offset <= char_offset_next;
      token_start <= token_start_next;
      line_count  <= line_count_next;
    end
  end

  // output queue
  logic [1:0] n_push;
  assign n_push = in_fire ? (2'(e0_valid) + 2'(e1_valid)) : 2'd0;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      if (e0_valid) begin
        queue[wr_ptr] <= e0;
        if (e1_valid) queue[wr_ptr + 2'd1] <= e1;
      end else begin
        queue[wr_ptr] <= e1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (out_fire) rd_ptr <= rd_ptr + 2'd1;
      count  <= count + 3'(n_push) - 3'(out_fire);
    end
  end

  // result word
  exlex_pkg::tok_t head;
  assign head    = queue[rd_ptr];
  assign m_tdata = {3'b000, head.line, head.len, head.start, head.kind};
  assign m_tlast = head.last;

endmodule
